[hdl/p2h_pkg.sv]
// ----------------------------------------------------------------------------
// p2h_pkg
// Shared widths and constants for the pixel to hex converter.
// ----------------------------------------------------------------------------
package p2h_pkg;

  // Port widths
  localparam int unsigned PIXEL_W      = 16;
  localparam int unsigned HEX_W        = 16;
  localparam int unsigned SIZE_RECIP_W = 17;

  // Fraction bits of size_recip and of the sqrt(3)/3 constant
  localparam int unsigned SCALE_FRAC = 16;
  localparam int unsigned SQRT3_FRAC = 24;

  // Default fraction bits of the internal axial coordinates
  localparam int unsigned FRAC_BITS_DEF = 16;

  // sqrt(3)/3 in Q0.24
  localparam logic [SQRT3_FRAC-1:0] SQRT3_OVER_3_Q24 = 24'd9686330;

  // Pipeline depth, input register to output register
  localparam int unsigned P2H_STAGES = 6;

  // size_recip split as 3*div + mod; floor(n/3) = (n * MUL) >> SH, exact for 17-bit n
  localparam int unsigned     RECIP_DIV3_W   = SIZE_RECIP_W - 1;
  localparam logic [17:0]     RECIP_DIV3_MUL = 18'd87382;
  localparam int unsigned     RECIP_DIV3_SH  = 18;

  localparam logic [SIZE_RECIP_W-1:0] SIZE_RECIP_RESET = 17'd65536;
  localparam logic [RECIP_DIV3_W-1:0] SIZE_RECIP_RST_DIV3 =
    RECIP_DIV3_W'(SIZE_RECIP_RESET / 3);
  localparam logic [1:0] SIZE_RECIP_RST_MOD3 = 2'(SIZE_RECIP_RESET % 3);

endpackage

[hdl/pixel_to_hex_round.sv]
// ----------------------------------------------------------------------------
// pixel_to_hex_round
// Converts a signed pixel point to the pointy-top hex cell holding it, in
// axial (q, r) coordinates. The point is scaled by size_recip (unsigned
// Q1.16, reciprocal of the hex size), turned into fractional axial
// coordinates with FRAC_BITS fraction bits, and cube-rounded: q, r and s are
// rounded half away from zero and the one with the largest rounding error is
// rebuilt from the other two. Results are saturated to 16 bits. The block is
// a six-stage pipeline: while the output side does not stall, it takes one
// word per clock and returns one word per clock. pixel_ready_o only drops
// when the output word is held and every stage behind it is full. The longest
// stage is the 34 x 25 bit product for the sqrt(3)/3 term. The user must write
// size_recip through size_recip_we_i only while no word is in flight; the
// block itself does not enforce this. A write takes effect for the next accepted
// word. No clearing pass, no memories.
// ----------------------------------------------------------------------------
module pixel_to_hex_round
  import p2h_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      size_recip_we_i,
  input  logic [SIZE_RECIP_W-1:0]   size_recip_i,
  // pixel words in
  input  logic                      pixel_valid_i,
  output logic                      pixel_ready_o,
  input  logic signed [PIXEL_W-1:0] pixel_x_i,
  input  logic signed [PIXEL_W-1:0] pixel_y_i,
  // hex words out
  output logic                      hex_valid_o,
  input  logic                      hex_ready_i,
  output logic signed [HEX_W-1:0]   hex_q_o,
  output logic signed [HEX_W-1:0]   hex_r_o
);

  // --------------------------------------------------------------------------
  // Derived widths
  // --------------------------------------------------------------------------
  // MSH: left shift of the y terms when FRAC_BITS exceeds the scale fraction,
  // RSH: right shift when it falls short. QSH: sqrt(3)/3 product down to Q.F.
  localparam int unsigned MSH = (FRAC_BITS > SCALE_FRAC) ? FRAC_BITS - SCALE_FRAC : 0;
  localparam int unsigned RSH = (FRAC_BITS < SCALE_FRAC) ? SCALE_FRAC - FRAC_BITS : 0;
  localparam int unsigned QSH = SQRT3_FRAC + SCALE_FRAC - FRAC_BITS;

  localparam int unsigned XSW = PIXEL_W + SIZE_RECIP_W + 1;  // x * recip
  localparam int unsigned KW  = SQRT3_FRAC + 1;             // signed constant
  localparam int unsigned QPW = XSW + KW;                   // q_a product
  localparam int unsigned DW  = RECIP_DIV3_W;
  localparam int unsigned AW  = PIXEL_W + DW + 1;           // (2)y * div
  localparam int unsigned BW  = PIXEL_W + 3;                // (2)y * mod
  localparam int unsigned XW3 = BW + 1 + MSH;               // div-by-3 input
  localparam int unsigned SW  = AW + MSH + 1;               // y term sum
  localparam int unsigned WQ  = FRAC_BITS + PIXEL_W + 4;    // fractional axial
  localparam int unsigned WI  = WQ - FRAC_BITS + 1;         // rounded axial
  localparam int unsigned NST = P2H_STAGES;

  localparam logic signed [WI:0] SAT_HI = (WI+1)'((1 << (HEX_W - 1)) - 1);
  localparam logic signed [WI:0] SAT_LO = (WI+1)'(-(1 << (HEX_W - 1)));

  typedef struct packed {
    logic signed [WI-1:0]        val;
    logic        [FRAC_BITS-1:0] err;
  } rnd_t;

  // Round half away from zero; err is |v - val * 2^F|
  function automatic rnd_t round_away(logic signed [WQ-1:0] v);
    logic [WQ-1:0]        mag;
    logic [FRAC_BITS-1:0] fm;
    logic [WI-1:0]        n;
    rnd_t                 res;
    mag = v[WQ-1] ? WQ'(-v) : WQ'(v);
    fm  = mag[FRAC_BITS-1:0];
    n   = WI'(mag[WQ-1:FRAC_BITS]) + WI'(fm[FRAC_BITS-1]);
    res.val = v[WQ-1] ? $signed(-n) : $signed(n);
    res.err = fm[FRAC_BITS-1] ? (~fm + FRAC_BITS'(1)) : fm;
    return res;
  endfunction

  function automatic logic signed [HEX_W-1:0] sat_hex(logic signed [WI:0] v);
    logic signed [WI:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return HEX_W'(c);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration: keep size_recip together with its split 3*div + mod so the
  // y terms need no divider in the datapath.
  // --------------------------------------------------------------------------
  logic [SIZE_RECIP_W-1:0]    recip_q;
  logic [DW-1:0]              rdiv3_q;
  logic [1:0]                 rmod3_q;
  logic [SIZE_RECIP_W+17:0]   cfg_prod;
  logic [DW-1:0]              cfg_div3;
  logic [SIZE_RECIP_W-1:0]    cfg_three;
  logic [SIZE_RECIP_W-1:0]    cfg_rem;

  assign cfg_prod  = (SIZE_RECIP_W+18)'(size_recip_i) * (SIZE_RECIP_W+18)'(RECIP_DIV3_MUL);
  assign cfg_div3  = cfg_prod[RECIP_DIV3_SH +: DW];
  assign cfg_three = (SIZE_RECIP_W'(cfg_div3) << 1) + SIZE_RECIP_W'(cfg_div3);
  assign cfg_rem   = size_recip_i - cfg_three;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_q <= SIZE_RECIP_RESET;
      rdiv3_q <= SIZE_RECIP_RST_DIV3;
      rmod3_q <= SIZE_RECIP_RST_MOD3;
    end else if (size_recip_we_i) begin
      recip_q <= size_recip_i;
      rdiv3_q <= cfg_div3;
      rmod3_q <= cfg_rem[1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: one valid bit per stage, a stage loads when it is empty
  // or the stage after it moves on. Nothing is dropped or duplicated on stall.
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic [NST-1:0] vld_d;
  logic [NST-1:0] vld_in;
  logic [NST-1:0] rdy;
  logic [NST-1:0] en;

  assign vld_in = {vld_q[NST-2:0], pixel_valid_i};

  always_comb begin
    rdy[NST-1] = !vld_q[NST-1] || hex_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign en    = rdy & vld_in;
  assign vld_d = (rdy & vld_in) | (~rdy & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pixel_ready_o = rdy[0];
  assign hex_valid_o   = vld_q[NST-1];

  // --------------------------------------------------------------------------
  // Stage 1: scale. xs = x * recip; y * recip is kept as y*3*div + y*mod,
  // and the same for 2y, so that later only a small value is divided by 3.
  // --------------------------------------------------------------------------
  logic signed [PIXEL_W:0]  py2;
  logic signed [XSW-1:0]    xs_d,  xs_q;
  logic signed [AW-1:0]     ya_d,  ya_q;
  logic signed [AW-1:0]     ra_d,  ra_q;
  logic signed [BW-1:0]     yb_d,  yb_q;
  logic signed [BW-1:0]     rb_d,  rb_q;

  assign py2  = {pixel_y_i, 1'b0};
  assign xs_d = pixel_x_i * $signed({1'b0, recip_q});
  assign ya_d = pixel_y_i * $signed({1'b0, rdiv3_q});
  assign ra_d = py2 * $signed({1'b0, rdiv3_q});
  assign yb_d = pixel_y_i * $signed({1'b0, rmod3_q});
  assign rb_d = py2 * $signed({1'b0, rmod3_q});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      xs_q <= xs_d;
      ya_q <= ya_d;
      ra_q <= ra_d;
      yb_q <= yb_d;
      rb_q <= rb_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sqrt(3)/3 product, and floor(mod term * 2^MSH / 3) for y and 2y.
  // --------------------------------------------------------------------------
  logic signed [QPW-1:0] qprod_d, qprod_q;
  logic signed [AW-1:0]  ya2_q;
  logic signed [AW-1:0]  ra2_q;
  logic signed [XW3-1:0] ydiv_x, rdiv_x;
  logic signed [XW3-1:0] ydiv_quo, rdiv_quo;

  assign qprod_d = xs_q * $signed({1'b0, SQRT3_OVER_3_Q24});
  assign ydiv_x  = XW3'(yb_q) <<< MSH;
  assign rdiv_x  = XW3'(rb_q) <<< MSH;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      qprod_q <= qprod_d;
      ya2_q   <= ya_q;
      ra2_q   <= ra_q;
    end
  end

  p2h_div3 #(
    .XW (XW3)
  ) u_div3_y (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .x_i   (ydiv_x),
    .quo_o (ydiv_quo)
  );

  p2h_div3 #(
    .XW (XW3)
  ) u_div3_r (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .x_i   (rdiv_x),
    .quo_o (rdiv_quo)
  );

  // --------------------------------------------------------------------------
  // Stage 3: fractional q and r in Q.FRAC_BITS. Floors nest, so the 1/3 is
  // taken first and the 2^RSH afterwards.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] ysum, rsum;
  logic signed [WQ-1:0] qa, y3;
  logic signed [WQ-1:0] qf_d, qf_q;
  logic signed [WQ-1:0] rf_d, rf_q;

  assign ysum = (SW'(ya2_q) <<< MSH) + SW'(ydiv_quo);
  assign rsum = (SW'(ra2_q) <<< MSH) + SW'(rdiv_quo);
  assign qa   = WQ'(qprod_q >>> QSH);
  assign y3   = WQ'(ysum >>> RSH);
  assign rf_d = WQ'(rsum >>> RSH);
  assign qf_d = qa - y3;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      qf_q <= qf_d;
      rf_q <= rf_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: s = -q - r
  // --------------------------------------------------------------------------
  logic signed [WQ-1:0] q4_q, r4_q, s4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      q4_q <= qf_q;
      r4_q <= rf_q;
      s4_q <= -qf_q - rf_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: round all three, keep the rounding errors
  // --------------------------------------------------------------------------
  rnd_t rq_q, rr_q, rs_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      rq_q <= round_away(q4_q);
      rr_q <= round_away(r4_q);
      rs_q <= round_away(s4_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: rebuild the worst coordinate, saturate, output register.
  // q wins only on a strict lead over both; ties fall to r, then s.
  // --------------------------------------------------------------------------
  logic signed [WI:0]      qx, rx, sx;
  logic signed [WI:0]      qsel, rsel;
  logic signed [HEX_W-1:0] hex_q_d, hex_q_q;
  logic signed [HEX_W-1:0] hex_r_d, hex_r_q;

  always_comb begin
    qx   = (WI+1)'($signed(rq_q.val));
    rx   = (WI+1)'($signed(rr_q.val));
    sx   = (WI+1)'($signed(rs_q.val));
    qsel = qx;
    rsel = rx;
    if (rq_q.err > rr_q.err && rq_q.err > rs_q.err) begin
      qsel = -rx - sx;
    end else if (rr_q.err > rs_q.err) begin
      rsel = -qx - sx;
    end
    hex_q_d = sat_hex(qsel);
    hex_r_d = sat_hex(rsel);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      hex_q_q <= hex_q_d;
      hex_r_q <= hex_r_d;
    end
  end

  assign hex_q_o = hex_q_q;
  assign hex_r_o = hex_r_q;

endmodule

[hdl/p2h_div3.sv]
// ----------------------------------------------------------------------------
// p2h_div3
// Signed floor division by three, reciprocal multiply, one register stage.
// ----------------------------------------------------------------------------
module p2h_div3 #(
  parameter int unsigned XW = 20
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  output logic signed [XW-1:0] quo_o
);

  // bias x into [2^XW, 2^(XW+1)) so the multiply sees a positive value
  localparam int unsigned NW = XW + 1;
  localparam int unsigned SH = NW + 2;
  localparam int unsigned MW = NW + 1;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'd2) / 64'd3);
  localparam logic [NW-1:0] BIAS  = NW'(64'd3 << (XW - 1));
  localparam logic [XW-1:0] OFFS  = XW'(64'd1 << (XW - 1));

  logic [NW-1:0]    biased;
  logic [NW+MW-1:0] prod_d;
  logic [NW+MW-1:0] prod_q;

  assign biased = NW'(x_i) + BIAS;
  assign prod_d = (NW+MW)'(biased) * (NW+MW)'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // floor(biased/3) - 2^(XW-1) == floor(x/3)
  assign quo_o = $signed(prod_q[SH +: XW] - OFFS);

endmodule

[hdl/p2h_checker.sv]
// ----------------------------------------------------------------------------
// p2h_checker
// Port-level checks for pixel_to_hex_round, bound to the top level.
// ----------------------------------------------------------------------------
module p2h_checker
  import p2h_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      size_recip_we_i,
  input logic [SIZE_RECIP_W-1:0]   size_recip_i,
  input logic                      pixel_valid_i,
  input logic                      pixel_ready_o,
  input logic                      hex_valid_o,
  input logic                      hex_ready_i,
  input logic signed [HEX_W-1:0]   hex_q_o,
  input logic signed [HEX_W-1:0]   hex_r_o
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] cnt_d, cnt_q;
  logic       zero_d, zero_q;

  assign in_acc  = pixel_valid_i && pixel_ready_o;
  assign out_acc = hex_valid_o && hex_ready_i;
  assign cnt_d   = cnt_q + 4'(in_acc) - 4'(out_acc);
  assign zero_d  = size_recip_we_i ? (size_recip_i == '0) : zero_q;

  // words in flight, and whether the scale is currently zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      zero_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      zero_q <= zero_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_valid_o && !hex_ready_i |=> hex_valid_o && $stable(hex_q_o) && $stable(hex_r_o))
    else $error("hex word changed while stalled");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(P2H_STAGES))
    else $error("more words in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 4'd0 |-> !hex_valid_o)
    else $error("hex word without a pixel word in flight");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 4'd0 |-> pixel_ready_o)
    else $error("empty pipeline refuses input");

  a_zero_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_q && hex_valid_o |-> hex_q_o == '0 && hex_r_o == '0)
    else $error("zero scale must give hex origin");

endmodule

bind pixel_to_hex_round p2h_checker u_p2h_checker (.*);

[tb/pixel_to_hex_round_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_to_hex_round_test
// Self-checking bench for the pixel to hex converter. Pixel words go in
// through valid/ready. Each accepted word is run through a fixed-point model
// of the pointy-top conversion and cube rounding, and the expected cell is
// queued. A checker compares every output word with the oldest entry.
// Directed cases cover the default scale, rounding ties, saturation, a zero
// scale, the minimum scale and one long output hold-off. Random phases follow
// under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module pixel_to_hex_round_test;
  import p2h_pkg::*;

  localparam int     HALF_PERIOD     = 5;
  localparam int     RESET_CYCLES    = 12;
  localparam int     STALL_LIMIT     = 4000;   // cycles with no word moving
  localparam int     HOLD_OFF_CYCLES = 400;    // long output stall
  localparam int     RANDOM_PHASES   = 8;
  localparam int     PHASE_WORDS     = 74;
  localparam int     MAX_REPORTS     = 10;
  localparam longint SQRT3_THIRD_Q24 = 64'd9686330;  // sqrt(3)/3 in Q0.24

  typedef struct packed {
    logic signed [HEX_W-1:0] q;
    logic signed [HEX_W-1:0] r;
  } hex_t;

  typedef enum int {
    MIX_NONE,
    MIX_SEND,
    MIX_RECV,
    MIX_BOTH
  } idle_mix_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      size_recip_we = 1'b0;
  logic [SIZE_RECIP_W-1:0]   size_recip    = SIZE_RECIP_RESET;
  logic                      pixel_valid   = 1'b0;
  logic                      pixel_ready;
  logic signed [PIXEL_W-1:0] pixel_x       = '0;
  logic signed [PIXEL_W-1:0] pixel_y       = '0;
  logic                      hex_valid;
  logic                      hex_ready     = 1'b0;
  logic signed [HEX_W-1:0]   hex_q;
  logic signed [HEX_W-1:0]   hex_r;

  // Scale the block is using, mirrored for prediction
  logic [SIZE_RECIP_W-1:0] cur_recip = SIZE_RECIP_RESET;

  hex_t hex_expect[$];   // predicted cells, oldest first

  int words_sent     = 0;
  int words_checked  = 0;
  int hex_mismatches = 0;
  int scale_writes   = 0;
  int stall_cycles   = 0;

  // Idling knobs, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;

  pixel_to_hex_round u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .size_recip_we_i (size_recip_we),
    .size_recip_i    (size_recip),
    .pixel_valid_i   (pixel_valid),
    .pixel_ready_o   (pixel_ready),
    .pixel_x_i       (pixel_x),
    .pixel_y_i       (pixel_y),
    .hex_valid_o     (hex_valid),
    .hex_ready_i     (hex_ready),
    .hex_q_o         (hex_q),
    .hex_r_o         (hex_r)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Division rounding toward minus infinity; divisor is always positive here
  function automatic longint floor_quot(longint n, longint d);
    longint quo;
    quo = n / d;
    if ((n % d) != 0 && n < 0) begin
      quo -= 1;
    end
    return quo;
  endfunction

  // Nearest integer of a fixed-point value, ties away from zero.
  // err gets the absolute distance, still in fixed point.
  function automatic longint round_half_away(longint v, output longint err);
    longint mag, n, rv;
    mag = (v < 0) ? -v : v;
    n   = (mag + (longint'(1) <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
    rv  = (v < 0) ? -n : n;
    err = v - (rv <<< FRAC_BITS_DEF);
    if (err < 0) begin
      err = -err;
    end
    return rv;
  endfunction

  function automatic logic signed [HEX_W-1:0] clamp_hex(longint v);
    if (v > 32767) begin
      return HEX_W'(32767);
    end
    if (v < -32768) begin
      return HEX_W'(-32768);
    end
    return HEX_W'(v);
  endfunction

  // Hex cell holding a pixel point at the given reciprocal cell size
  function automatic hex_t predict_hex(logic signed [PIXEL_W-1:0] px,
                                       logic signed [PIXEL_W-1:0] py,
                                       logic [SIZE_RECIP_W-1:0]   recip);
    longint xs, ys, den, qf, rf, sf;
    longint qi, ri, si, qerr, rerr, serr;
    hex_t   hex_pt;
    xs  = longint'(px) * longint'(recip);   // Q.16
    ys  = longint'(py) * longint'(recip);
    den = longint'(3) <<< SCALE_FRAC;
    // q = sqrt(3)/3 * x - y/3, r = 2/3 * y, s closes the cube
    qf  = ((xs * SQRT3_THIRD_Q24) >>> (SQRT3_FRAC + SCALE_FRAC - FRAC_BITS_DEF))
        - floor_quot(ys <<< FRAC_BITS_DEF, den);
    rf  = floor_quot((2 * ys) <<< FRAC_BITS_DEF, den);
    sf  = -qf - rf;
    qi  = round_half_away(qf, qerr);
    ri  = round_half_away(rf, rerr);
    si  = round_half_away(sf, serr);
    // rebuild the worst-rounded axis; q only wins on a strict maximum
    if (qerr > rerr && qerr > serr) begin
      qi = -ri - si;
    end else if (rerr > serr) begin
      ri = -qi - si;
    end
    hex_pt.q = clamp_hex(qi);
    hex_pt.r = clamp_hex(ri);
    return hex_pt;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: ready pattern with optional long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      hex_ready <= 1'b0;
    end else begin
      hex_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted output word with the oldest prediction.
  // Sampled right at the edge, so values are the ones the handshake saw.
  always @(posedge clk_i) begin : check_hex
    hex_t want;
    if (rst_ni && hex_valid && hex_ready) begin
      if (hex_expect.size() == 0) begin
        if (hex_mismatches < MAX_REPORTS) begin
          $display("[%0t] unexpected hex word q=%0d r=%0d", $realtime, hex_q, hex_r);
        end
        hex_mismatches++;
      end else begin
        want = hex_expect.pop_front();
        if (hex_q !== want.q || hex_r !== want.r) begin
          if (hex_mismatches < MAX_REPORTS) begin
            $display("[%0t] hex word %0d: expected q=%0d r=%0d, got q=%0d r=%0d",
                     $realtime, words_checked, want.q, want.r, hex_q, hex_r);
          end
          hex_mismatches++;
        end
      end
      words_checked++;
    end
  end

  // Watchdog: a run that stops moving words ends as a failure
  always @(posedge clk_i) begin
    if ((pixel_valid && pixel_ready) || (hex_valid && hex_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] no word moved for %0d cycles", $realtime, stall_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  task automatic set_mix(input idle_mix_e mix);
    case (mix)
      MIX_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      MIX_SEND: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      MIX_RECV: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default:  begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  // Offer one pixel word and return at the edge that accepted it.
  // Valid is only dropped when an idle gap is taken, so back-to-back
  // words keep it high without a second assignment in the same step.
  task automatic send_pixel(input logic signed [PIXEL_W-1:0] x,
                            input logic signed [PIXEL_W-1:0] y);
    if ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    pixel_valid <= 1'b1;
    pixel_x     <= x;
    pixel_y     <= y;
    do @(posedge clk_i); while (!pixel_ready);
    hex_expect.push_back(predict_hex(x, y, cur_recip));
    words_sent++;
  endtask

  // Stop offering and let every predicted word come out
  task automatic drain;
    pixel_valid <= 1'b0;
    while (hex_expect.size() != 0) @(posedge clk_i);
  endtask

  // Scale changes only with the pipeline empty
  task automatic write_size_recip(input logic [SIZE_RECIP_W-1:0] value);
    drain();
    size_recip_we <= 1'b1;
    size_recip    <= value;
    @(posedge clk_i);
    size_recip_we <= 1'b0;
    cur_recip = value;
    scale_writes++;
  endtask

  // Mix of full-range, near-origin and extreme coordinates
  function automatic logic signed [PIXEL_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return PIXEL_W'($urandom);
      4, 5:       return PIXEL_W'(int'($urandom_range(0, 400)) - 200);
      6:          return PIXEL_W'(int'($urandom_range(0, 16)) - 32768);
      default:    return PIXEL_W'(32767 - int'($urandom_range(0, 16)));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Scale as it comes out of reset (cell size one)
  task automatic test_reset_scale;
    set_mix(MIX_NONE);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(-1, -1);
    send_pixel(1, -1);
    send_pixel(32767, 32767);
    send_pixel(-32768, -32768);
    send_pixel(-32768, 32767);
    send_pixel(32767, -32768);
  endtask

  // Exact halves: at this scale y=1 puts r on +0.5, y=2 puts q and s on -0.5
  task automatic test_rounding_ties;
    write_size_recip(17'd49152);
    send_pixel(0, 1);
    send_pixel(0, -1);
    send_pixel(0, 2);
    send_pixel(0, -2);
  endtask

  // Largest scale drives the cell coordinates past 16 bits
  task automatic test_saturation;
    write_size_recip({SIZE_RECIP_W{1'b1}});
    send_pixel(32767, 0);
    send_pixel(-32768, 0);
    send_pixel(0, 32767);
    send_pixel(0, -32768);
    send_pixel(32767, -32768);
  endtask

  // Zero scale folds every point onto the origin cell
  task automatic test_zero_scale;
    write_size_recip('0);
    send_pixel(32767, -32768);
    send_pixel(-32768, 32767);
    send_pixel(123, -456);
  endtask

  task automatic test_min_scale;
    write_size_recip(17'd1);
    send_pixel(32767, 32767);
    send_pixel(-32768, -32768);
  endtask

  // Hold the output off long enough that the pipeline fills and
  // pixel_ready has to drop while words keep being offered
  task automatic test_output_hold_off;
    write_size_recip(SIZE_RECIP_RESET);
    set_mix(MIX_NONE);
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (40) send_pixel(rand_coord(), rand_coord());
  endtask

  // Random words, new scale and idling mix per phase
  task automatic test_random_phases;
    logic [SIZE_RECIP_W-1:0] recip;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0, 1:    recip = SIZE_RECIP_W'($urandom_range(1, 65536));
        2:       recip = SIZE_RECIP_W'($urandom_range(1, 1024));      // big cells
        3:       recip = SIZE_RECIP_W'($urandom_range(65537, 131071)); // sub-pixel cells
        4:       recip = SIZE_RECIP_W'($urandom_range(16384, 65536));
        default: recip = SIZE_RECIP_RESET;
      endcase
      write_size_recip(recip);
      set_mix(idle_mix_e'(ph % 4));
      repeat (PHASE_WORDS) send_pixel(rand_coord(), rand_coord());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_scale();
    test_rounding_ties();
    test_saturation();
    test_zero_scale();
    test_min_scale();
    test_output_hold_off();
    test_random_phases();

    drain();
    // wait for any stray word to come out
    repeat (3 * P2H_STAGES) @(posedge clk_i);

    $display("%0d pixel words sent, %0d checked across %0d scale writes (zero, min, max, ties)",
             words_sent, words_checked, scale_writes);
    $display("idling: none, sender, receiver, both, plus a %0d-cycle output hold-off",
             HOLD_OFF_CYCLES);
    if (hex_mismatches == 0 && hex_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d words still expected", hex_mismatches,
               hex_expect.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
